// ===== hdl/scanline_unfilter_core_assert.svh =====
// Assertion macros shared by the scanline unfilter checker.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef SCANLINE_UNFILTER_CORE_ASSERT_SVH
`define SCANLINE_UNFILTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SU_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("scanline_unfilter_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SU_ASSERT_NXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("scanline_unfilter_core: next-cycle check failed");

`endif

// ===== hdl/su_pkg.sv =====
// Shared types, codes and helper functions for the scanline unfilter.
// No dependencies; imported by the core, the checker and the testbench.
`timescale 1ns / 1ps

package su_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_byte;
		logic       last_byte;
	} su_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       row_done;
		logic       image_done;
		logic [2:0] status_code;
	} su_out_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_COLOR_MODE   = 2'd0;
	localparam logic [1:0] CFG_SAMPLE_BITS  = 2'd1;
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd3;

	localparam int CFG_DATA_W = 17;

	// Result status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_CFG    = 3'd1;
	localparam logic [2:0] ST_BAD_FILTER = 3'd2;
	localparam logic [2:0] ST_SHORT      = 3'd3;
	localparam logic [2:0] ST_ROW_LONG   = 3'd4;

	// Row filter types.
	localparam logic [2:0] FLT_NONE  = 3'd0;
	localparam logic [2:0] FLT_SUB   = 3'd1;
	localparam logic [2:0] FLT_UP    = 3'd2;
	localparam logic [2:0] FLT_AVG   = 3'd3;
	localparam logic [2:0] FLT_PAETH = 3'd4;

	// Colour types.
	localparam logic [2:0] CM_GRAY       = 3'd0;
	localparam logic [2:0] CM_RGB        = 3'd2;
	localparam logic [2:0] CM_INDEXED    = 3'd3;
	localparam logic [2:0] CM_GRAY_ALPHA = 3'd4;
	localparam logic [2:0] CM_RGBA       = 3'd6;

	function automatic logic [2:0] channel_count(input logic [2:0] mode);
		logic [2:0] n;
		unique case (mode)
			CM_GRAY:       n = 3'd1;
			CM_RGB:        n = 3'd3;
			CM_INDEXED:    n = 3'd1;
			CM_GRAY_ALPHA: n = 3'd2;
			CM_RGBA:       n = 3'd4;
			default:       n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic depth_ok(input logic [2:0] mode, input logic [4:0] bits);
		logic low;
		logic ok;
		low = (bits == 5'd1) || (bits == 5'd2) || (bits == 5'd4);
		unique case (mode)
			CM_GRAY:    ok = low || (bits == 5'd8) || (bits == 5'd16);
			CM_RGB, CM_GRAY_ALPHA, CM_RGBA:
			            ok = (bits == 5'd8) || (bits == 5'd16);
			CM_INDEXED: ok = low || (bits == 5'd8);
			default:    ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Log2 of a legal bit depth; other depths are rejected elsewhere.
	function automatic logic [2:0] depth_log2(input logic [4:0] bits);
		logic [2:0] s;
		unique case (bits)
			5'd2:    s = 3'd1;
			5'd4:    s = 3'd2;
			5'd8:    s = 3'd3;
			5'd16:   s = 3'd4;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] p;
		logic signed [9:0] pa;
		logic signed [9:0] pb;
		logic signed [9:0] pc;
		logic [7:0] r;
		p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
		pa = p - $signed({2'b00, a});
		pb = p - $signed({2'b00, b});
		pc = p - $signed({2'b00, c});
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if ((pa <= pb) && (pa <= pc)) r = a;
		else if (pb <= pc) r = b;
		else r = c;
		return r;
	endfunction

endpackage

// ===== hdl/su_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; used for the previous-row line store.
`timescale 1ns / 1ps

module su_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/scanline_unfilter_core.sv =====
// Scanline unfilter core: rebuilds raw PNG bytes from the filtered, inflated stream.
// Throughput is one item per cycle unless the output or a configuration write stalls;
// a data byte is decoded into s1, then reconstructed into the output register.
// A configuration write holds in_ready low in its own cycle and the next one.
// arst_n clears all control state; the line store holds no reset and needs no clear pass.
// Depends on su_pkg and su_ram.
`timescale 1ns / 1ps

module scanline_unfilter_core
	import su_pkg::*;
#(
	parameter int MAX_ROW_BYTES   = 8192,
	parameter int MAX_PIXEL_BYTES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  su_in_t                in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output su_out_t               out_item,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Column counter width: a column is always below the row length, which is at most
	// MAX_ROW_BYTES once the row length check has passed.
	localparam int COL_W     = $clog2(MAX_ROW_BYTES);
	localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [2:0]  color_mode_q;
	logic [4:0]  sample_bits_q;
	logic [16:0] image_width_q;
	logic [15:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q   <= CM_GRAY;
			sample_bits_q  <= 5'd8;
			image_width_q  <= 17'd1;
			image_height_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_COLOR_MODE:   color_mode_q   <= cfg_wdata[2:0];
				CFG_SAMPLE_BITS:  sample_bits_q  <= cfg_wdata[4:0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[16:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Derived geometry. The user must change the configuration only while the block is
	// idle; the block itself does not enforce this. The row length, pixel stride and error
	// flags are registered from it. A legal depth is a power of two, so width times depth
	// is a shift, and the channel count is a tiny 3-bit multiplier.
	// ------------------------------------------------------------------
	logic [2:0]     chans;
	logic [20:0]    width_shifted;
	logic [22:0]    row_bits;
	logic [22:0]    row_bits_rnd;
	logic [19:0]    row_bytes_full;
	logic [3:0]     bpp_full;
	logic [3:0]     bpp_cap;
	logic           cfg_bad;
	logic           row_long;

	logic           cfg_bad_q;
	logic           row_long_q;
	logic [COL_W:0] row_bytes_q;
	logic [3:0]     bpp_q;
	logic           cfg_block_q;

	always_comb begin
		chans          = channel_count(color_mode_q);
		width_shifted  = {4'b0000, image_width_q} << depth_log2(sample_bits_q);
		row_bits       = {2'b00, width_shifted} * {20'd0, chans};
		row_bits_rnd   = row_bits + 23'd7;
		row_bytes_full = row_bits_rnd[22:3];
		bpp_full       = (sample_bits_q == 5'd16) ? {chans, 1'b0} : {1'b0, chans};
		bpp_cap        = (bpp_full > 4'(MAX_PIXEL_BYTES)) ? 4'(MAX_PIXEL_BYTES) : bpp_full;
		cfg_bad        = !depth_ok(color_mode_q, sample_bits_q) ||
		                 (image_width_q == 17'd0) || (image_height_q == 16'd0);
		row_long       = row_bytes_full > 20'(MAX_ROW_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bad_q   <= 1'b0;
			row_long_q  <= 1'b0;
			row_bytes_q <= (COL_W+1)'(1);
			bpp_q       <= 4'd1;
			cfg_block_q <= 1'b0;
		end else begin
			cfg_bad_q   <= cfg_bad;
			row_long_q  <= row_long;
			row_bytes_q <= row_bytes_full[COL_W:0];
			bpp_q       <= bpp_cap;
			// cfg_block_q keeps input waiting while the derived registers follow a write.
			cfg_block_q <= cfg_we;
		end
	end

	// ------------------------------------------------------------------
	// Handshake. The reconstruct stage (s1) and the output register form a two-entry
	// pipeline; an item is taken whenever s1 is empty or moving on, barring config writes.
	// ------------------------------------------------------------------
	logic s1_valid;
	logic s1_adv;
	logic in_acc;
	logic out_valid_q;

	assign s1_adv   = s1_valid && (!out_valid_q || out_ready);
	assign in_ready = !cfg_we && !cfg_block_q && (!s1_valid || s1_adv);
	assign in_acc   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Decode stage: all sequencing decisions depend only on control state and the
	// incoming byte, so they are made at acceptance. A first_byte restarts the
	// image before anything else is looked at.
	// ------------------------------------------------------------------
	logic             halted_q;
	logic             expect_q;
	logic [15:0]      row_q;
	logic [COL_W-1:0] col_q;
	logic [2:0]       filter_q;

	logic             eff_halted;
	logic             eff_expect;
	logic [15:0]      eff_row;
	logic [COL_W-1:0] eff_col;
	logic             row_end;
	logic             img_end;
	logic             has_left;
	logic             has_up;

	logic             s0_emit;
	logic             s0_is_data;
	logic [2:0]       s0_status;

	logic             nxt_halted;
	logic             nxt_expect;
	logic [15:0]      nxt_row;
	logic [COL_W-1:0] nxt_col;
	logic [2:0]       nxt_filter;

	always_comb begin
		eff_halted = in_item.first_byte ? 1'b0 : halted_q;
		eff_expect = in_item.first_byte ? 1'b1 : expect_q;
		eff_row    = in_item.first_byte ? 16'd0 : row_q;
		eff_col    = in_item.first_byte ? '0 : col_q;

		row_end  = ({1'b0, eff_col} + (COL_W+1)'(1)) >= row_bytes_q;
		img_end  = row_end && (({1'b0, eff_row} + 17'd1) >= {1'b0, image_height_q});
		has_left = {1'b0, eff_col} >= (COL_W+1)'(bpp_q);
		has_up   = eff_row != 16'd0;

		s0_emit    = 1'b0;
		s0_is_data = 1'b0;
		s0_status  = ST_OK;
		nxt_halted = halted_q;
		nxt_expect = expect_q;
		nxt_row    = row_q;
		nxt_col    = col_q;
		nxt_filter = filter_q;

		if (in_acc) begin
			nxt_halted = eff_halted;
			nxt_expect = eff_expect;
			nxt_row    = eff_row;
			nxt_col    = eff_col;
			if (!eff_halted) begin
				if (cfg_bad_q) begin
					s0_emit    = 1'b1;
					s0_status  = ST_BAD_CFG;
					nxt_halted = 1'b1;
				end else if (row_long_q) begin
					s0_emit    = 1'b1;
					s0_status  = ST_ROW_LONG;
					nxt_halted = 1'b1;
				end else if (eff_expect) begin
					if (in_item.in_byte > {5'd0, FLT_PAETH}) begin
						s0_emit    = 1'b1;
						s0_status  = ST_BAD_FILTER;
						nxt_halted = 1'b1;
					end else if (in_item.last_byte) begin
						// Stream ends where a row should begin.
						s0_emit    = 1'b1;
						s0_status  = ST_SHORT;
						nxt_halted = 1'b1;
					end else begin
						nxt_filter = in_item.in_byte[2:0];
						nxt_col    = '0;
						nxt_expect = 1'b0;
					end
				end else begin
					s0_emit    = 1'b1;
					s0_is_data = 1'b1;
					if (row_end) begin
						nxt_col    = '0;
						nxt_row    = eff_row + 16'd1;
						nxt_expect = 1'b1;
					end else begin
						nxt_col = eff_col + COL_W'(1);
					end
					if (img_end) begin
						nxt_halted = 1'b1;
					end else if (in_item.last_byte) begin
						// Data byte that ends the stream before the image is complete.
						nxt_halted = 1'b1;
						s0_status  = ST_SHORT;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
			expect_q <= 1'b1;
			row_q    <= 16'd0;
			col_q    <= '0;
			filter_q <= FLT_NONE;
		end else begin
			halted_q <= nxt_halted;
			expect_q <= nxt_expect;
			row_q    <= nxt_row;
			col_q    <= nxt_col;
			filter_q <= nxt_filter;
		end
	end

	// ------------------------------------------------------------------
	// Line store. The upper byte is read at acceptance so that it arrives with the
	// item in s1. The only overlap is a read of the column that s1 writes in the
	// same cycle; that case is forwarded from the reconstructed byte. Read data and
	// the forward flag only change on a read, so they hold while s1 is stalled.
	// ------------------------------------------------------------------
	logic [7:0]       ram_rdata;
	logic             ram_we;
	logic [COL_W-1:0] s1_col;
	logic [7:0]       x_byte;
	logic             fwd_q;
	logic [7:0]       fwd_byte_q;

	assign ram_we = s1_adv && s1_is_data_w();

	// s1_is_data is declared below; a small function keeps the read order obvious.
	logic s1_is_data;
	function automatic logic s1_is_data_w();
		return s1_is_data;
	endfunction

	su_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ROW_BYTES)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(s1_col),
		.wdata(x_byte),
		.re   (in_acc),
		.raddr(eff_col),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (in_acc) begin
			fwd_q <= ram_we && (s1_col == eff_col);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fwd_byte_q <= x_byte;
		end
	end

	// ------------------------------------------------------------------
	// Reconstruct stage (s1).
	// ------------------------------------------------------------------
	logic [2:0] s1_status;
	logic [7:0] s1_byte;
	logic [2:0] s1_filter;
	logic       s1_has_left;
	logic       s1_has_up;
	logic       s1_row_end;
	logic       s1_img_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_acc) begin
			s1_valid <= s0_emit;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s0_emit) begin
			s1_is_data  <= s0_is_data;
			s1_status   <= s0_status;
			s1_byte     <= in_item.in_byte;
			s1_filter   <= filter_q;
			s1_col      <= eff_col;
			s1_has_left <= has_left;
			s1_has_up   <= has_up;
			s1_row_end  <= row_end;
			s1_img_end  <= img_end;
		end
	end

	// Neighbor history: one pixel deep, newest byte at index 0. Entries are only
	// used once the row has advanced a full pixel, so no clearing is needed.
	logic [7:0]           left_q [MAX_PIXEL_BYTES];
	logic [7:0]           ul_q   [MAX_PIXEL_BYTES];
	logic [PIX_IDX_W-1:0] bpp_idx;
	logic [7:0]           up_raw;
	logic [7:0]           nb_a;
	logic [7:0]           nb_b;
	logic [7:0]           nb_c;
	logic [8:0]           ab_sum;
	logic [7:0]           pred;

	always_comb begin
		bpp_idx = PIX_IDX_W'(bpp_q - 4'd1);
		up_raw  = fwd_q ? fwd_byte_q : ram_rdata;
		nb_a    = s1_has_left ? left_q[bpp_idx] : 8'd0;
		nb_b    = s1_has_up ? up_raw : 8'd0;
		nb_c    = (s1_has_left && s1_has_up) ? ul_q[bpp_idx] : 8'd0;
		ab_sum  = {1'b0, nb_a} + {1'b0, nb_b};
		case (s1_filter)
			FLT_SUB:   pred = nb_a;
			FLT_UP:    pred = nb_b;
			FLT_AVG:   pred = ab_sum[8:1];
			FLT_PAETH: pred = paeth_pred(nb_a, nb_b, nb_c);
			default:   pred = 8'd0;
		endcase
		x_byte = s1_byte + pred;
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			left_q[0] <= x_byte;
			ul_q[0]   <= nb_b;
			for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= left_q[i-1];
				ul_q[i]   <= ul_q[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register. Results without a data byte carry zeros besides the status.
	// ------------------------------------------------------------------
	su_out_t out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (s1_is_data) begin
				out_item_q.out_byte   <= x_byte;
				out_item_q.row_done   <= s1_row_end;
				out_item_q.image_done <= s1_img_end;
			end else begin
				out_item_q.out_byte   <= 8'd0;
				out_item_q.row_done   <= 1'b0;
				out_item_q.image_done <= 1'b0;
			end
			out_item_q.status_code <= s1_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== hdl/su_checker.sv =====
// Port-level checks for scanline_unfilter_core, attached by bind.
// Depends on su_pkg and scanline_unfilter_core_assert.svh.
`timescale 1ns / 1ps
`include "scanline_unfilter_core_assert.svh"

module su_checker
	import su_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input su_out_t out_item,
	input logic    cfg_we
);

	`SU_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))

	`SU_ASSERT_IMP(a_image_ends_row, clk, arst_n, out_valid && out_item.image_done, out_item.row_done)

	`SU_ASSERT_IMP(a_error_fields_zero, clk, arst_n, out_valid && (out_item.status_code == ST_BAD_CFG || out_item.status_code == ST_BAD_FILTER || out_item.status_code == ST_ROW_LONG), out_item.out_byte == 8'd0 && !out_item.row_done && !out_item.image_done)

	`SU_ASSERT_IMP(a_short_not_done, clk, arst_n, out_valid && out_item.status_code == ST_SHORT, !out_item.image_done)

	`SU_ASSERT_NXT(a_cfg_blocks_input, clk, arst_n, cfg_we, !in_ready)

endmodule

bind scanline_unfilter_core su_checker u_su_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for scanline_unfilter_core, the streaming PNG row unfilter.
// A small scoreboard class predicts every result from its own copy of the registers and
// row history; plain tasks drive items and register writes. Depends on su_pkg and the core.

module tb_top;
	import su_pkg::*;

	localparam int ROW_CAP     = 8192;
	localparam int PIX_CAP     = 8;
	localparam int CYCLE_LIMIT = 400000;
	// Colour type codes that the PNG format leaves unused; the block must reject them.
	localparam logic [2:0] CM_UNUSED_A = 3'd1;
	localparam logic [2:0] CM_UNUSED_B = 3'd5;
	localparam logic [2:0] CM_UNUSED_C = 3'd7;

	// Scoreboard: keeps its own image of the block's registers and row history, turns
	// each accepted item into the result it must cause, and checks results in order.
	class unfilter_scoreboard;
		logic [2:0]  mode;
		logic [4:0]  depth;
		logic [16:0] width;
		logic [15:0] height;
		logic [7:0]  line_store [ROW_CAP];
		logic [7:0]  left_hist [PIX_CAP];
		logic [7:0]  diag_hist [PIX_CAP];
		logic [2:0]  filt;
		int unsigned col;
		logic [15:0] row;
		bit          want_filter;
		bit          stopped;
		su_out_t     expected_q [$];
		int          errors;

		function new();
			mode = CM_GRAY;
			depth = 5'd8;
			width = 17'd1;
			height = 16'd1;
			foreach (line_store[i])
				line_store[i] = '0;
			clear_history();
			filt = FLT_NONE;
			col = 0;
			row = '0;
			want_filter = 1'b1;
			stopped = 1'b0;
			errors = 0;
		endfunction

		function void clear_history();
			foreach (left_hist[i]) begin
				left_hist[i] = '0;
				diag_hist[i] = '0;
			end
		endfunction

		function void set_reg(logic [1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				CFG_COLOR_MODE:   mode = data[2:0];
				CFG_SAMPLE_BITS:  depth = data[4:0];
				CFG_IMAGE_WIDTH:  width = data[16:0];
				CFG_IMAGE_HEIGHT: height = data[15:0];
				default: ;
			endcase
		endfunction

		function int unsigned lanes();
			case (mode)
				CM_GRAY, CM_INDEXED: return 1;
				CM_GRAY_ALPHA:       return 2;
				CM_RGB:              return 3;
				CM_RGBA:             return 4;
				default:             return 0;
			endcase
		endfunction

		function bit depth_legal();
			case (depth)
				5'd1, 5'd2, 5'd4: return mode == CM_GRAY || mode == CM_INDEXED;
				5'd8:             return lanes() != 0;
				5'd16:            return mode != CM_INDEXED && lanes() != 0;
				default:          return 1'b0;
			endcase
		endfunction

		function int unsigned row_len();
			int unsigned bits;
			bits = 32'(width) * 32'(depth) * lanes();
			return (bits + 7) / 8;
		endfunction

		function logic [2:0] cfg_status();
			if (!depth_legal() || width == 0 || height == 0)
				return ST_BAD_CFG;
			if (row_len() > ROW_CAP)
				return ST_ROW_LONG;
			return ST_OK;
		endfunction

		// Paeth choice written with the distances in closed form.
		function int paeth_pick(int a, int b, int c);
			int da, db, dc;
			da = b - c;
			db = a - c;
			dc = a + b - 2 * c;
			if (da < 0) da = -da;
			if (db < 0) db = -db;
			if (dc < 0) dc = -dc;
			if (da <= db && da <= dc)
				return a;
			if (db <= dc)
				return b;
			return c;
		endfunction

		function void fail(logic [2:0] st);
			stopped = 1'b1;
			expected_q.push_back('{out_byte: 8'h00, row_done: 1'b0, image_done: 1'b0,
				status_code: st});
		endfunction

		// Returns 1 when the block acts on the item, 0 when it must ignore it.
		function bit note(su_in_t it);
			int unsigned bpp;
			int unsigned a, b, c, pred;
			logic [7:0] x;
			logic [2:0] st;
			bit has_left, row_end, img_end;
			if (it.first_byte) begin
				stopped = 1'b0;
				want_filter = 1'b1;
				row = '0;
				col = 0;
				clear_history();
			end
			if (stopped)
				return 1'b0;
			st = cfg_status();
			if (st != ST_OK) begin
				fail(st);
				return 1'b1;
			end
			bpp = ((32'(depth) + 7) / 8) * lanes();
			if (bpp > PIX_CAP)
				bpp = PIX_CAP;
			if (want_filter) begin
				if (it.in_byte > FLT_PAETH) begin
					fail(ST_BAD_FILTER);
					return 1'b1;
				end
				if (it.last_byte) begin
					fail(ST_SHORT);
					return 1'b1;
				end
				filt = it.in_byte[2:0];
				col = 0;
				clear_history();
				want_filter = 1'b0;
				return 1'b1;
			end
			has_left = col >= bpp;
			a = has_left ? left_hist[bpp-1] : 0;
			b = (row != 0 && col < ROW_CAP) ? line_store[col] : 0;
			c = (has_left && row != 0) ? diag_hist[bpp-1] : 0;
			case (filt)
				FLT_SUB:   pred = a;
				FLT_UP:    pred = b;
				FLT_AVG:   pred = (a + b) / 2;
				FLT_PAETH: pred = paeth_pick(a, b, c);
				default:   pred = 0;
			endcase
			x = it.in_byte + pred[7:0];
			for (int i = PIX_CAP - 1; i > 0; i--) begin
				left_hist[i] = left_hist[i-1];
				diag_hist[i] = diag_hist[i-1];
			end
			left_hist[0] = x;
			diag_hist[0] = b[7:0];
			if (col < ROW_CAP)
				line_store[col] = x;
			row_end = (col + 1) >= row_len();
			img_end = row_end && (32'(row) + 1 >= 32'(height));
			if (row_end) begin
				col = 0;
				row = row + 16'd1;
				want_filter = 1'b1;
			end else begin
				col = col + 1;
			end
			st = ST_OK;
			if (img_end) begin
				stopped = 1'b1;
			end else if (it.last_byte) begin
				stopped = 1'b1;
				st = ST_SHORT;
			end
			expected_q.push_back('{out_byte: x, row_done: row_end, image_done: img_end,
				status_code: st});
			return 1'b1;
		endfunction

		function void check(su_out_t got);
			su_out_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: out_byte %0h status_code %0d",
					got.out_byte, got.status_code);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte mismatch: expected %0h, actual %0h", want.out_byte,
					got.out_byte);
				errors++;
			end
			if (got.row_done !== want.row_done) begin
				$error("row_done mismatch: expected %0b, actual %0b", want.row_done,
					got.row_done);
				errors++;
			end
			if (got.image_done !== want.image_done) begin
				$error("image_done mismatch: expected %0b, actual %0b", want.image_done,
					got.image_done);
				errors++;
			end
			if (got.status_code !== want.status_code) begin
				$error("status_code mismatch: expected %0d, actual %0d", want.status_code,
					got.status_code);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// One register setting of the run, with how many acted-on items to spend on it.
	// A budget of zero means a single clean image at that setting.
	typedef struct {
		logic [2:0]  mode;
		logic [4:0]  bits;
		logic [16:0] w;
		logic [15:0] h;
		int          budget;
	} image_setup_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	su_in_t                in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	su_out_t               out_item;
	logic                  cfg_we = 1'b0;
	logic [1:0]            cfg_addr = CFG_COLOR_MODE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	unfilter_scoreboard sb;
	int cycle = 0;
	int taken = 0;

	scanline_unfilter_core #(
		.MAX_ROW_BYTES(ROW_CAP),
		.MAX_PIXEL_BYTES(PIX_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both sides hold back in about a quarter of the cycles, except in one long window
	// early in the random part where the block runs at full rate in both directions.
	function automatic bit stall_roll();
		return (cycle < 1500 || cycle >= 4500) && ($urandom_range(0, 99) < 24);
	endfunction

	// The receiver changes its ready only at the falling edge.
	always @(negedge clk)
		out_ready <= !stall_roll();

	// Handshakes are sampled at the rising edge. A result can never leave on the same
	// edge as the item that caused it, so checking before noting is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check(out_item);
			if (in_valid && in_ready && sb.note(in_item))
				taken++;
		end
	end

	// Watchdog: a run that hangs is a failure.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic image_setup_t setup(logic [2:0] mode, logic [4:0] bits,
			logic [16:0] w, logic [15:0] h, int budget);
		image_setup_t s;
		s.mode = mode;
		s.bits = bits;
		s.w = w;
		s.h = h;
		s.budget = budget;
		return s;
	endfunction

	// Data bytes lean toward the two extremes now and then.
	function automatic logic [7:0] data_byte();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return $urandom;
	endfunction

	// Offers one item at a falling edge, after a random number of idle cycles, and
	// returns once the block has taken it. Valid stays high on return, so the next call
	// either presents its item or drops valid at the next falling edge.
	task automatic push(logic [7:0] b, bit first, bit last);
		@(negedge clk);
		while (stall_roll()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{in_byte: b, first_byte: first, last_byte: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drops valid and waits until every expected result has left the block. Filter bytes
	// cause no result, so it then waits longer to let the two-stage pipe empty.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(logic [1:0] addr, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		sb.set_reg(addr, data);
	endtask

	// Registers change only with the block drained and no item on offer.
	task automatic apply_setup(image_setup_t s);
		settle();
		put_reg(CFG_COLOR_MODE, CFG_DATA_W'(s.mode));
		put_reg(CFG_SAMPLE_BITS, CFG_DATA_W'(s.bits));
		put_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(s.w));
		put_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(s.h));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Builds one image for the current setting and sends it. Most images are whole,
	// with random filters and data; the rest are cut short (with or without the end
	// flag), carry a bad filter type in some row, or are replaced by loose noise.
	// Tall images stop after a few rows, so they end as short streams.
	task automatic play_image(bit plain);
		su_in_t seq [$];
		su_in_t it;
		int unsigned rows, rlen, kind, cut, spot;
		rlen = sb.row_len();
		rows = (sb.height > 6) ? $urandom_range(1, 3) : sb.height;
		for (int r = 0; r < rows; r++) begin
			it.first_byte = (r == 0);
			it.last_byte = 1'b0;
			it.in_byte = $urandom_range(FLT_NONE, FLT_PAETH);
			seq.push_back(it);
			it.first_byte = 1'b0;
			for (int k = 0; k < rlen; k++) begin
				it.in_byte = data_byte();
				seq.push_back(it);
			end
		end
		seq[seq.size()-1].last_byte = 1'b1;
		kind = plain ? 0 : $urandom_range(0, 99);
		if (kind >= 70 && kind < 84) begin
			// Cut anywhere, the filter byte included; without the end flag the image is
			// simply abandoned and the next one restarts the block.
			cut = $urandom_range(0, seq.size() - 1);
			while (seq.size() > cut + 1)
				void'(seq.pop_back());
			seq[cut].last_byte = $urandom_range(0, 1);
		end else if (kind >= 84 && kind < 92) begin
			spot = $urandom_range(0, rows - 1) * (rlen + 1);
			seq[spot].in_byte = $urandom_range(5, 255);
		end else if (kind >= 92) begin
			seq.delete();
			repeat ($urandom_range(1, 5)) begin
				it.in_byte = $urandom;
				it.first_byte = ($urandom_range(0, 3) == 0);
				it.last_byte = ($urandom_range(0, 3) == 0);
				seq.push_back(it);
			end
		end
		foreach (seq[i])
			push(seq[i].in_byte, seq[i].first_byte, seq[i].last_byte);
		// A stray byte after the image is normally ignored by the halted block.
		if (!plain && $urandom_range(0, 9) == 0)
			push($urandom, 1'b0, $urandom_range(0, 1));
	endtask

	// Under a rejected setting every restart reports the error once, and the bytes
	// that follow it are ignored.
	task automatic play_rejected();
		push($urandom, 1'b1, 1'b0);
		repeat (5)
			push($urandom, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
	endtask

	initial begin
		image_setup_t plan [$];
		int goal;
		sb = new();

		// Settings for the random part: every legal colour type and depth, illegal ones,
		// zero sizes, rows beyond the line store, the widest legal row and the tallest
		// image, and every register bit set at least once.
		plan.push_back(setup(CM_GRAY, 5'd8, 17'd4, 16'd3, 110));
		plan.push_back(setup(CM_UNUSED_A, 5'd8, 17'd4, 16'd2, 0));
		plan.push_back(setup(CM_GRAY, 5'd1, 17'd13, 16'd3, 110));
		plan.push_back(setup(CM_GRAY, 5'd2, 17'd7, 16'd4, 110));
		plan.push_back(setup(CM_RGB, 5'd4, 17'd3, 16'd2, 0));
		plan.push_back(setup(CM_GRAY, 5'd4, 17'd5, 16'd2, 110));
		plan.push_back(setup(CM_GRAY, 5'd16, 17'd3, 16'd3, 110));
		plan.push_back(setup(CM_GRAY, 5'd0, 17'd3, 16'd3, 0));
		plan.push_back(setup(CM_RGB, 5'd8, 17'd2, 16'd3, 110));
		plan.push_back(setup(CM_RGB, 5'd16, 17'd1, 16'd2, 110));
		plan.push_back(setup(CM_GRAY, 5'd31, 17'd2, 16'd2, 0));
		plan.push_back(setup(CM_INDEXED, 5'd1, 17'd20, 16'd2, 110));
		plan.push_back(setup(CM_INDEXED, 5'd2, 17'd9, 16'd3, 110));
		plan.push_back(setup(CM_INDEXED, 5'd16, 17'd2, 16'd2, 0));
		plan.push_back(setup(CM_INDEXED, 5'd4, 17'd3, 16'd3, 110));
		plan.push_back(setup(CM_INDEXED, 5'd8, 17'd6, 16'd3, 110));
		plan.push_back(setup(CM_GRAY, 5'd8, 17'd0, 16'd3, 0));
		plan.push_back(setup(CM_GRAY_ALPHA, 5'd8, 17'd3, 16'd2, 110));
		plan.push_back(setup(CM_GRAY_ALPHA, 5'd16, 17'd2, 16'd3, 110));
		plan.push_back(setup(CM_GRAY, 5'd8, 17'd4, 16'd0, 0));
		plan.push_back(setup(CM_RGBA, 5'd8, 17'd2, 16'd2, 110));
		plan.push_back(setup(CM_RGBA, 5'd16, 17'd2, 16'd2, 110));
		plan.push_back(setup(CM_UNUSED_B, 5'd16, 17'd5, 16'd5, 0));
		plan.push_back(setup(CM_GRAY, 5'd8, 17'd65536, 16'd2, 0));
		plan.push_back(setup(CM_RGBA, 5'd16, 17'h1FFFF, 16'hFFFF, 0));
		plan.push_back(setup(CM_UNUSED_C, 5'd31, 17'h1FFFF, 16'hFFFF, 0));
		plan.push_back(setup(CM_INDEXED, 5'd8, 17'd1, 16'hFFFF, 110));
		plan.push_back(setup(CM_GRAY, 5'd1, 17'd65536, 16'd2, 0));
		plan.push_back(setup(CM_GRAY, 5'd1, 17'h1FFFF, 16'd4, 0));
		plan.push_back(setup(CM_RGB, 5'd8, 17'd3, 16'd4, 110));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Straight out of reset, without any restart flag: the block already waits for
		// a filter byte, and the default one-pixel image ends on its only data byte.
		push(FLT_NONE, 1'b0, 1'b0);
		push(8'hA5, 1'b0, 1'b0);

		// Two-byte gray rows, one per filter type, several with extreme data bytes.
		apply_setup(setup(CM_GRAY, 5'd8, 17'd2, 16'd5, 0));
		push(FLT_NONE, 1'b1, 1'b0);
		push(8'h00, 1'b0, 1'b0);
		push(8'hFF, 1'b0, 1'b0);
		push(FLT_SUB, 1'b0, 1'b0);
		push(8'hFF, 1'b0, 1'b0);
		push(8'h01, 1'b0, 1'b0);
		push(FLT_UP, 1'b0, 1'b0);
		push(8'h80, 1'b0, 1'b0);
		push(8'h7F, 1'b0, 1'b0);
		push(FLT_AVG, 1'b0, 1'b0);
		push(8'hFF, 1'b0, 1'b0);
		push(8'hFF, 1'b0, 1'b0);
		push(FLT_PAETH, 1'b0, 1'b0);
		push(8'h12, 1'b0, 1'b0);
		push(8'hF0, 1'b0, 1'b1);
		// Filter type out of range, then a byte the halted block must ignore.
		push(8'hFF, 1'b1, 1'b0);
		push(8'h05, 1'b0, 1'b0);
		// Stream ending on a filter byte, then on a data byte inside the image.
		push(FLT_SUB, 1'b1, 1'b1);
		push(FLT_PAETH, 1'b1, 1'b0);
		push(8'h3C, 1'b0, 1'b1);

		foreach (plan[p]) begin
			apply_setup(plan[p]);
			if (sb.cfg_status() != ST_OK) begin
				play_rejected();
			end else if (plan[p].budget == 0) begin
				play_image(1'b1);
			end else begin
				goal = taken + plan[p].budget;
				while (taken < goal) begin
					play_image(1'b0);
					// Now and then the sender waits for the block to drain completely.
					if ($urandom_range(0, 7) == 0)
						settle();
				end
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
